[src/ptu_pkg.sv]
// Shared constants, opcodes and memory port types of the two-level page table unit.
// Used by the interfaces, the controller, the top level and the checker.
package ptu_pkg;

	localparam int DIR_SLOTS       = 1024;
	localparam int TABLE_ENTRIES   = 1024;
	localparam int IDENTITY_TABLES = 32;
	localparam int IDENT_TABLES    = (IDENTITY_TABLES > DIR_SLOTS) ? DIR_SLOTS : IDENTITY_TABLES;

	localparam int DIR_AW    = $clog2(DIR_SLOTS);
	localparam int TBL_AW    = $clog2(TABLE_ENTRIES);
	localparam int ENT_AW    = DIR_AW + TBL_AW;
	localparam int TBL_DEPTH = 1 << ENT_AW;

	localparam int OP_W      = 2;
	localparam int ADDR_W    = 32;
	localparam int FLAG_W    = 12;
	localparam int IDX_W     = 10;
	localparam int FRAME_W   = ADDR_W - FLAG_W;
	localparam int DIR_SHIFT = 22;
	localparam int TBL_SHIFT = 12;

	localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
	localparam logic [OP_W-1:0] OP_UNMAP = 2'd1;
	localparam logic [OP_W-1:0] OP_XLATE = 2'd2;

	localparam logic [ADDR_W-1:0] FALLBACK_RESET = 32'h0800_0000;
	localparam logic [FLAG_W-1:0] FLAG_PRESENT   = 12'h001;
	localparam logic [FLAG_W-1:0] DIR_INIT_FLAGS = 12'h003;

	typedef struct packed {
		logic              we;
		logic [DIR_AW-1:0] waddr;
		logic [FLAG_W-1:0] wdata;
		logic              re;
		logic [DIR_AW-1:0] raddr;
	} dir_port_t;

	typedef struct packed {
		logic              we;
		logic [ENT_AW-1:0] waddr;
		logic [ADDR_W-1:0] wdata;
		logic              re;
		logic [ENT_AW-1:0] raddr;
	} tbl_port_t;

endpackage

[src/ptu_if.sv]
// Request and response channel interfaces of the page table unit.
// Depends on ptu_pkg for the field widths.
interface ptu_req_if import ptu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [ADDR_W-1:0] virt_addr;
	logic [ADDR_W-1:0] phys_addr;
	logic [FLAG_W-1:0] page_flags;

	modport source(output valid, opcode, virt_addr, phys_addr, page_flags, input ready);
	modport sink(input valid, opcode, virt_addr, phys_addr, page_flags, output ready);
endinterface

interface ptu_rsp_if import ptu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] phys_result;

	modport source(output valid, phys_result, input ready);
	modport sink(input valid, phys_result, output ready);
endinterface

[src/ptu_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first: a read and a write to the same address in the same cycle return the old data.
module ptu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/ptu_ctrl.sv]
// Sequencer and datapath of the page table unit: reset fill, lookup, table clearing.
// Depends on ptu_pkg and ptu_if; drives the directory and table RAM ports.
module ptu_ctrl import ptu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ptu_req_if.sink           req,
	ptu_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	output dir_port_t         dir_port,
	input  logic [FLAG_W-1:0] dir_rdata,
	output tbl_port_t         tbl_port,
	input  logic [ADDR_W-1:0] tbl_rdata
);

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	logic [1:0]         state_q;
	logic [DIR_AW-1:0]  t_q;
	logic [TBL_AW-1:0]  p_q;
	logic [ADDR_W-1:0]  limit_q;
	logic               rsp_valid_q;
	logic [ADDR_W-1:0]  rsp_data_q;

	logic [OP_W-1:0]    op_s1;
	logic [ADDR_W-1:0]  virt_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic [FLAG_W-1:0]  flags_s1;
	logic               inside_s1;

	logic               dir_fwd_q;
	logic [FLAG_W-1:0]  dir_fwd_data_q;
	logic               tbl_fwd_q;
	logic [ADDR_W-1:0]  tbl_fwd_data_q;

	logic [FLAG_W-1:0]  dir_cur;
	logic [ADDR_W-1:0]  ent_cur;
	logic               present;
	logic               is_map;
	logic               is_unmap;
	logic               need_clear;
	logic               out_free;
	logic               clear_last;
	logic               ident_row;
	logic               look_done;
	logic               clear_done;
	logic               done;
	logic               accept;
	logic [ADDR_W-1:0]  new_entry;
	logic [ADDR_W-1:0]  xlate;
	logic [ADDR_W-1:0]  result;
	logic [DIR_AW-1:0]  di_s1;
	logic [TBL_AW-1:0]  ti_s1;
	logic               req_inside;

	// The RAM output register only changes on a read, so the forwarded copy stays valid
	// for as long as the looked-up item waits.
	assign dir_cur    = dir_fwd_q ? dir_fwd_data_q : dir_rdata;
	assign ent_cur    = tbl_fwd_q ? tbl_fwd_data_q : tbl_rdata;
	assign present    = dir_cur[0];
	assign di_s1      = virt_s1[DIR_SHIFT +: DIR_AW];
	assign ti_s1      = virt_s1[TBL_SHIFT +: TBL_AW];
	assign is_map     = (op_s1 == OP_MAP) && inside_s1;
	assign is_unmap   = (op_s1 == OP_UNMAP) && inside_s1;
	assign need_clear = is_map && !present;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign clear_last = (p_q == TBL_AW'(TABLE_ENTRIES - 1));
	assign ident_row  = (32'(t_q) < 32'(IDENT_TABLES));
	assign look_done  = (state_q == ST_LOOK) && out_free && !need_clear;
	assign clear_done = (state_q == ST_CLEAR) && out_free && clear_last;
	assign done       = look_done || clear_done;
	assign req.ready  = (state_q == ST_IDLE) || done;
	assign accept     = req.valid && req.ready;
	assign new_entry  = {frame_s1, flags_s1 | FLAG_PRESENT};

	assign req_inside = (32'(req.virt_addr[ADDR_W-1:DIR_SHIFT]) < 32'(DIR_SLOTS))
		&& (32'(req.virt_addr[DIR_SHIFT-1:TBL_SHIFT]) < 32'(TABLE_ENTRIES));

	always_comb begin
		if (inside_s1 && present && ent_cur[0]) begin
			xlate = {ent_cur[ADDR_W-1:FLAG_W], virt_s1[FLAG_W-1:0]};
		end else if (virt_s1 < limit_q) begin
			xlate = virt_s1;
		end else begin
			xlate = '0;
		end
		result = ((state_q == ST_LOOK) && (op_s1 == OP_XLATE)) ? xlate : '0;
	end

	always_comb begin
		dir_port       = '0;
		tbl_port       = '0;
		dir_port.re    = accept;
		dir_port.raddr = req.virt_addr[DIR_SHIFT +: DIR_AW];
		tbl_port.re    = accept;
		tbl_port.raddr = {req.virt_addr[DIR_SHIFT +: DIR_AW], req.virt_addr[TBL_SHIFT +: TBL_AW]};
		unique case (state_q)
			ST_INIT: begin
				if (ident_row) begin
					tbl_port.we    = 1'b1;
					tbl_port.waddr = {t_q, p_q};
					tbl_port.wdata = {IDX_W'(t_q), IDX_W'(p_q), 10'd0, DIR_INIT_FLAGS[1:0]};
					dir_port.we    = (p_q == '0);
					dir_port.waddr = t_q;
					dir_port.wdata = DIR_INIT_FLAGS;
				end else begin
					dir_port.we    = 1'b1;
					dir_port.waddr = t_q;
					dir_port.wdata = '0;
				end
			end
			ST_LOOK: begin
				dir_port.waddr = di_s1;
				tbl_port.waddr = {di_s1, ti_s1};
				if (need_clear) begin
					dir_port.we    = 1'b1;
					dir_port.wdata = flags_s1 | FLAG_PRESENT;
				end else if (out_free) begin
					if (is_map) begin
						dir_port.we    = 1'b1;
						dir_port.wdata = dir_cur | flags_s1;
						tbl_port.we    = 1'b1;
						tbl_port.wdata = new_entry;
					end else if (is_unmap && present) begin
						tbl_port.we    = 1'b1;
						tbl_port.wdata = '0;
					end
				end
			end
			ST_CLEAR: begin
				// The mapped entry is written in place while the sweep passes over it.
				tbl_port.we    = 1'b1;
				tbl_port.waddr = {di_s1, p_q};
				tbl_port.wdata = (p_q == ti_s1) ? new_entry : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			t_q         <= '0;
			p_q         <= '0;
			limit_q     <= FALLBACK_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (ident_row && !clear_last) begin
						p_q <= p_q + 1'b1;
					end else begin
						p_q <= '0;
						if (t_q == DIR_AW'(DIR_SLOTS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							t_q <= t_q + 1'b1;
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (need_clear) begin
						state_q <= ST_CLEAR;
						p_q     <= '0;
					end else if (out_free) begin
						state_q <= accept ? ST_LOOK : ST_IDLE;
					end
				end
				ST_CLEAR: begin
					if (!clear_last) begin
						p_q <= p_q + 1'b1;
					end else if (out_free) begin
						state_q <= accept ? ST_LOOK : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_data_q <= result;
		end
		if (accept) begin
			op_s1          <= req.opcode;
			virt_s1        <= req.virt_addr;
			frame_s1       <= req.phys_addr[ADDR_W-1:FLAG_W];
			flags_s1       <= req.page_flags;
			inside_s1      <= req_inside;
			dir_fwd_q      <= dir_port.we && (dir_port.waddr == dir_port.raddr);
			dir_fwd_data_q <= dir_port.wdata;
			tbl_fwd_q      <= tbl_port.we && (tbl_port.waddr == tbl_port.raddr);
			tbl_fwd_data_q <= tbl_port.wdata;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.phys_result = rsp_data_q;

endmodule

[src/two_level_page_table_unit.sv]
// The result is registered once the lookup of an accepted request is done; a map that
// opens an absent directory slot first sweeps its table in ST_CLEAR.
// Otherwise one request per cycle, set by the one read port of each RAM, while no
// response is stalled. After reset a fill pass writes the directory and identity tables;
// no request is taken during the pass.
// The fallback limit register resets to 128 MiB and can be written during the pass.
module two_level_page_table_unit import ptu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ptu_req_if.sink           req,
	ptu_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata
);

	dir_port_t         dir_port;
	tbl_port_t         tbl_port;
	logic [FLAG_W-1:0] dir_rdata;
	logic [ADDR_W-1:0] tbl_rdata;

	ptu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.dir_port  (dir_port),
		.dir_rdata (dir_rdata),
		.tbl_port  (tbl_port),
		.tbl_rdata (tbl_rdata)
	);

	ptu_ram #(.WIDTH(FLAG_W), .DEPTH(DIR_SLOTS)) u_dir_ram (
		.clk   (clk),
		.we    (dir_port.we),
		.waddr (dir_port.waddr),
		.wdata (dir_port.wdata),
		.re    (dir_port.re),
		.raddr (dir_port.raddr),
		.rdata (dir_rdata)
	);

	ptu_ram #(.WIDTH(ADDR_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_port.we),
		.waddr (tbl_port.waddr),
		.wdata (tbl_port.wdata),
		.re    (tbl_port.re),
		.raddr (tbl_port.raddr),
		.rdata (tbl_rdata)
	);

endmodule

[src/ptu_checker.sv]
// Port-level checker for the page table unit, bound to the top level.
// Depends on ptu_pkg for widths and opcodes.
module ptu_checker import ptu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic [OP_W-1:0]   req_opcode,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [ADDR_W-1:0] rsp_phys_result
);

	logic       push;
	logic       pop;
	logic [1:0] cnt_q;
	logic [1:0] base;
	logic       zero0_q;
	logic       zero1_q;

	assign push = req_valid && req_ready;
	assign pop  = rsp_valid && rsp_ready;
	assign base = cnt_q - {1'b0, pop};

	// Tracks the requests in flight and whether each one must answer zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			zero0_q <= 1'b0;
			zero1_q <= 1'b0;
		end else begin
			cnt_q <= base + {1'b0, push};
			if (pop) begin
				zero0_q <= zero1_q;
			end
			if (push) begin
				if (base == 2'd0) begin
					zero0_q <= (req_opcode != OP_XLATE);
				end else begin
					zero1_q <= (req_opcode != OP_XLATE);
				end
			end
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !req_ready && !rsp_valid)
		else $error("request taken or response shown during reset");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phys_result))
		else $error("stalled response changed");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cnt_q != 2'd0)
		else $error("response without a pending request");

	a_inflight: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("more than two requests in flight");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cnt_q != 2'd0 && zero0_q |-> rsp_phys_result == '0)
		else $error("map or unmap answered nonzero");

endmodule

bind two_level_page_table_unit ptu_checker u_ptu_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_opcode      (req.opcode),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_phys_result (rsp.phys_result)
);

[tb/tb_two_level_page_table_unit.sv]
// Self-checking testbench for the two-level page table unit: maps, unmaps and translations
// are checked against a behavioral copy of the directory and the page tables.
// Depends on ptu_pkg, the ptu_req_if and ptu_rsp_if interfaces, and the unit itself.
`timescale 1ns / 1ps

module tb_two_level_page_table_unit;
	import ptu_pkg::*;

	localparam logic [OP_W-1:0]   OP_RESERVED = 2'd3;
	localparam logic [ADDR_W-1:0] FRAME_MASK  = 32'hFFFF_F000;
	localparam int                BATCH_ITEMS = 336;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [ADDR_W-1:0] virt_addr;
		logic [ADDR_W-1:0] phys_addr;
		logic [FLAG_W-1:0] page_flags;
	} pt_request_t;

	typedef struct packed {
		pt_request_t       req;
		logic [ADDR_W-1:0] phys_result;
	} pt_answer_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;

	ptu_req_if req_if();
	ptu_rsp_if rsp_if();

	two_level_page_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Behavioral copy of the unit's state.
	bit   [FLAG_W-1:0] slot_flags [DIR_SLOTS];
	bit   [ADDR_W-1:0] pte_image  [DIR_SLOTS*TABLE_ENTRIES];
	logic [ADDR_W-1:0] limit_model;

	pt_request_t pending_reqs[$];
	pt_answer_t  expected_results[$];

	int mismatches;
	int n_map, n_unmap, n_xlate, n_other, n_opened, n_hits, n_results;

	int hot_slots [8] = '{32, 33, 47, 100, 511, 512, 1022, 1023};
	int hot_pages [8] = '{0, 1, 2, 37, 511, 512, 900, 1023};

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatches++;
	endtask

	// Applies one request to the table copy and returns the physical address it answers.
	function automatic logic [ADDR_W-1:0] walk_page_table(pt_request_t r);
		int unsigned       slot;
		int unsigned       page;
		int unsigned       ent;
		bit                in_range;
		logic [ADDR_W-1:0] answer;
		slot     = r.virt_addr >> DIR_SHIFT;
		page     = (r.virt_addr >> TBL_SHIFT) & ((1 << IDX_W) - 1);
		in_range = slot < DIR_SLOTS && page < TABLE_ENTRIES;
		ent      = slot * TABLE_ENTRIES + page;
		answer   = '0;
		case (r.opcode)
			OP_MAP: begin
				n_map++;
				if (in_range) begin
					// Opening an absent slot starts its table from scratch.
					if (!slot_flags[slot][0]) begin
						for (int p = 0; p < TABLE_ENTRIES; p++)
							pte_image[slot*TABLE_ENTRIES + p] = '0;
						slot_flags[slot] = r.page_flags | FLAG_PRESENT;
						n_opened++;
					end else begin
						slot_flags[slot] = slot_flags[slot] | r.page_flags;
					end
					pte_image[ent] = (r.phys_addr & FRAME_MASK) |
						{{FRAME_W{1'b0}}, r.page_flags | FLAG_PRESENT};
				end
			end
			OP_UNMAP: begin
				n_unmap++;
				if (in_range && slot_flags[slot][0])
					pte_image[ent] = '0;
			end
			OP_XLATE: begin
				n_xlate++;
				if (in_range && slot_flags[slot][0] && pte_image[ent][0]) begin
					answer = {pte_image[ent][ADDR_W-1:TBL_SHIFT],
						r.virt_addr[TBL_SHIFT-1:0]};
					n_hits++;
				end else begin
					answer = (r.virt_addr < limit_model) ? r.virt_addr : '0;
				end
			end
			default: begin
				n_other++;
			end
		endcase
		return answer;
	endfunction

	function automatic pt_request_t make_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] va,
			logic [ADDR_W-1:0] pa, logic [FLAG_W-1:0] fl);
		pt_request_t r;
		r.opcode     = op;
		r.virt_addr  = va;
		r.phys_addr  = pa;
		r.page_flags = fl;
		return r;
	endfunction

	// Request driver: bursts of random length, most of them followed by a random gap.
	pt_request_t drv_item;
	bit          drv_busy;
	int          burst_left;
	int          gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid      <= 1'b0;
			req_if.opcode     <= '0;
			req_if.virt_addr  <= '0;
			req_if.phys_addr  <= '0;
			req_if.page_flags <= '0;
			drv_busy   = 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (drv_busy && req_if.ready) begin
				expected_results.push_back('{drv_item, walk_page_table(drv_item)});
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					drv_item = pending_reqs.pop_front();
					drv_busy = 1'b1;
					if (burst_left == 0)
						burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 10);
					burst_left--;
					if (burst_left == 0 && $urandom_range(0, 3) != 0)
						gap_left = $urandom_range(1, 8);
				end
			end
			req_if.valid      <= drv_busy;
			req_if.opcode     <= drv_item.opcode;
			req_if.virt_addr  <= drv_item.virt_addr;
			req_if.phys_addr  <= drv_item.phys_addr;
			req_if.page_flags <= drv_item.page_flags;
		end
	end

	// Long receiver hold-offs, triggered after a given number of results.
	int   hold_seen;
	int   hold_left;
	int   holds_done;
	logic rx_hold;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen  = 0;
			hold_left  = 0;
			holds_done = 0;
			rx_hold   <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready)
				hold_seen++;
			if (hold_left > 0) begin
				hold_left--;
			end else if ((holds_done == 0 && hold_seen >= 150) ||
					(holds_done == 1 && hold_seen >= 900)) begin
				hold_left = 400;
				holds_done++;
			end
			rx_hold <= (hold_left > 0);
		end
	end

	// Response monitor with its own stall pattern.
	logic [15:0] rx_pattern;
	int          rx_tick;
	pt_answer_t  want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			rx_pattern = 16'hFFFF;
			rx_tick    = 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %h with no request outstanding",
						rsp_if.phys_result));
				end else begin
					want = expected_results.pop_front();
					if (rsp_if.phys_result !== want.phys_result)
						report_mismatch($sformatf(
							"op %0d va %h pa %h fl %h: phys_result %h, expected %h",
							want.req.opcode, want.req.virt_addr, want.req.phys_addr,
							want.req.page_flags, rsp_if.phys_result, want.phys_result));
				end
			end
			rx_tick++;
			if (rx_tick % 48 == 0) begin
				case ($urandom_range(0, 3))
					0: rx_pattern = 16'hFFFF;
					1: rx_pattern = 16'($urandom);
					2: rx_pattern = 16'($urandom | $urandom);
					default: rx_pattern = 16'($urandom & $urandom);
				endcase
			end
			rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
			rsp_if.ready <= !rx_hold && rx_pattern[0];
		end
	end

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || drv_busy || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_fallback_limit(logic [ADDR_W-1:0] value);
		@(posedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= value;
		limit_model  = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_random_batch(int count);
		pt_request_t r;
		int          slot;
		int          page;
		int          sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45)
				slot = $urandom_range(0, IDENT_TABLES - 1);
			else if (sel < 85)
				slot = hot_slots[$urandom_range(0, 7)] % DIR_SLOTS;
			else
				slot = $urandom_range(0, DIR_SLOTS - 1);
			page = ($urandom_range(0, 9) < 6) ? hot_pages[$urandom_range(0, 7)] % TABLE_ENTRIES
				: $urandom_range(0, TABLE_ENTRIES - 1);
			r.virt_addr  = (ADDR_W'(slot) << DIR_SHIFT) | (ADDR_W'(page) << TBL_SHIFT) |
				ADDR_W'($urandom_range(0, 4095));
			r.phys_addr  = $urandom;
			r.page_flags = FLAG_W'($urandom_range(0, 4095));
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				r.opcode = OP_MAP;
			end else if (sel < 55) begin
				r.opcode = OP_UNMAP;
			end else if (sel < 95) begin
				r.opcode = OP_XLATE;
				// Probe the fallback boundary now and then.
				if ($urandom_range(0, 11) == 0)
					r.virt_addr = limit_model - ADDR_W'($urandom_range(0, 1));
			end else begin
				r.opcode = OP_RESERVED;
			end
			pending_reqs.push_back(r);
			// About half of the maps are read back right away through the same page.
			if (r.opcode == OP_MAP && $urandom_range(0, 1) == 1) begin
				r.opcode    = OP_XLATE;
				r.virt_addr = {r.virt_addr[ADDR_W-1:TBL_SHIFT], 12'($urandom_range(0, 4095))};
				pending_reqs.push_back(r);
				n++;
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		limit_model       = FALLBACK_RESET;
		for (int t = 0; t < IDENT_TABLES; t++) begin
			slot_flags[t] = DIR_INIT_FLAGS;
			for (int p = 0; p < TABLE_ENTRIES; p++)
				pte_image[t*TABLE_ENTRIES + p] = (ADDR_W'(t) << DIR_SHIFT) |
					(ADDR_W'(p) << TBL_SHIFT) | ADDR_W'(DIR_INIT_FLAGS);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests with the fallback limit at its reset value.
		pending_reqs.push_back(make_request(OP_XLATE, 32'h0000_0000, '0, '0));
		pending_reqs.push_back(make_request(OP_XLATE, 32'h07FF_FFFF, '0, '0));
		pending_reqs.push_back(make_request(OP_XLATE, 32'h0800_0000, '0, '0));
		pending_reqs.push_back(make_request(OP_XLATE, 32'hFFFF_FFFF, '0, '0));
		pending_reqs.push_back(make_request(OP_MAP, 32'hFFFF_F123, 32'hFFFF_FFFF, 12'hFFF));
		pending_reqs.push_back(make_request(OP_XLATE, 32'hFFFF_FABC, '0, '0));
		pending_reqs.push_back(make_request(OP_XLATE, 32'hFFC0_0000, '0, '0));
		pending_reqs.push_back(make_request(OP_MAP, 32'h0040_1000, 32'h1234_5000, 12'h000));
		pending_reqs.push_back(make_request(OP_XLATE, 32'h0040_1ABC, '0, '0));
		pending_reqs.push_back(make_request(OP_UNMAP, 32'h0040_1000, '0, '0));
		pending_reqs.push_back(make_request(OP_XLATE, 32'h0040_1ABC, '0, '0));
		pending_reqs.push_back(make_request(OP_UNMAP, 32'h0C00_0000, '0, '0));
		pending_reqs.push_back(make_request(OP_MAP, 32'h0C00_5000, 32'h0000_0FFF, 12'h002));
		pending_reqs.push_back(make_request(OP_XLATE, 32'h0C00_5FFF, '0, '0));
		pending_reqs.push_back(make_request(OP_RESERVED, 32'h0C00_5000, 32'hDEAD_B000, 12'h7FF));
		pending_reqs.push_back(make_request(OP_XLATE, 32'h0C00_5001, '0, '0));
		pending_reqs.push_back(make_request(OP_MAP, 32'h0000_0000, 32'h0000_0000, 12'hFFE));
		pending_reqs.push_back(make_request(OP_XLATE, 32'h0000_0FFF, '0, '0));
		pending_reqs.push_back(make_request(OP_UNMAP, 32'hFFFF_F000, '0, '0));
		pending_reqs.push_back(make_request(OP_XLATE, 32'hFFFF_F000, '0, '0));
		pending_reqs.push_back(make_request(OP_MAP, 32'h0800_0000, 32'hABCD_E000, 12'h800));
		pending_reqs.push_back(make_request(OP_XLATE, 32'h0800_0001, '0, '0));
		pending_reqs.push_back(make_request(OP_XLATE, 32'h0800_1001, '0, '0));
		wait_idle();

		// Random phases, each under its own fallback limit.
		write_fallback_limit('0);
		load_random_batch(BATCH_ITEMS);
		wait_idle();
		write_fallback_limit(32'hFFFF_FFFF);
		load_random_batch(BATCH_ITEMS);
		wait_idle();
		write_fallback_limit($urandom);
		load_random_batch(BATCH_ITEMS);
		wait_idle();
		write_fallback_limit($urandom_range(0, 32'h1000_0000));
		load_random_batch(BATCH_ITEMS);
		wait_idle();
		write_fallback_limit(FALLBACK_RESET);
		load_random_batch(BATCH_ITEMS);
		wait_idle();

		repeat (TABLE_ENTRIES + 16) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("Covered %0d maps (%0d opened a table), %0d unmaps, %0d translations",
			n_map, n_opened, n_unmap, n_xlate);
		$display("with %0d page hits, %0d reserved opcodes, %0d results, 6 fallback limits.",
			n_hits, n_other, n_results);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Timeout: the run did not finish in time.");
		$display("Some tests failed");
		$finish;
	end

endmodule
